// ===== rtl/ipava_pkg.sv =====
// shared types and constants of the isotonic pool-adjacent-violators fit
package ipava_pkg;

   localparam int MAX_LEN   = 64;
   localparam int IDX_W     = 6;
   localparam int CNT_W     = 7;
   localparam int DATA_W    = 32;
   localparam int SUM_W     = 38;
   localparam int PROD_W    = SUM_W + CNT_W + 1;
   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W    = 6;

   // controller states, one-hot
   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_READ  = 10'b0000000010,
      ST_MULT  = 10'b0000000100,
      ST_CMP   = 10'b0000001000,
      ST_FLUSH = 10'b0000010000,
      ST_ERD   = 10'b0000100000,
      ST_ELOAD = 10'b0001000000,
      ST_EDIV  = 10'b0010000000,
      ST_EOUT  = 10'b0100000000,
      ST_CLEAR = 10'b1000000000
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic rd_lo;
      logic mul;
      logic merge;
      logic flush;
      logic emit_rd;
      logic div_start;
      logic emit_out;
      logic clear;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic cap_ok;
      logic top_ge2;
      logic violates;
      logic div_busy;
      logic k_last;
      logic idx_last;
   } status_type;

endpackage

// ===== rtl/ipava_div.sv =====
// sequential signed-by-unsigned divider, one quotient bit per cycle
module ipava_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [ipava_pkg::SUM_W-1:0]   dividend,
   input  logic        [ipava_pkg::CNT_W-1:0]   divisor,
   output logic                                 busy,
   output logic        [ipava_pkg::DATA_W-1:0]  quotient
);

   logic                            busy_ff, busy_in;
   logic                            neg_ff, neg_in;
   logic [ipava_pkg::SUM_W-1:0]     dvd_ff, dvd_in;
   logic [ipava_pkg::CNT_W:0]       rem_ff, rem_in;
   logic [ipava_pkg::CNT_W-1:0]     div_ff, div_in;
   logic [ipava_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [ipava_pkg::CNT_W:0]       rem_sh;
   logic                            ge;
   logic [ipava_pkg::SUM_W-1:0]     q_signed;

   // one restoring step
   assign rem_sh = {rem_ff[ipava_pkg::CNT_W-1:0], dvd_ff[ipava_pkg::SUM_W-1]};
   assign ge     = (rem_sh >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[ipava_pkg::SUM_W-1];
         dvd_in  = dividend[ipava_pkg::SUM_W-1] ? -dividend : dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? (rem_sh - {1'b0, div_ff}) : rem_sh;
         dvd_in  = {dvd_ff[ipava_pkg::SUM_W-2:0], ge};
         step_in = step_ff + 1'b1;
         if (step_ff == ipava_pkg::STEP_W'(ipava_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff  <= neg_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
   end

   // truncation toward zero: negate magnitude quotient
   assign q_signed = neg_ff ? -dvd_ff : dvd_ff;
   assign quotient = q_signed[ipava_pkg::DATA_W-1:0];
   assign busy     = busy_ff;

endmodule

// ===== rtl/ipava_dp.sv =====
// datapath: pool stack memory, top pool registers, merge test and readout
module ipava_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ipava_pkg::cmd_type                   cmd,
   output ipava_pkg::status_type                status,
   input  logic signed [ipava_pkg::DATA_W-1:0]  sample_value,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data,
   output logic signed [ipava_pkg::DATA_W-1:0]  fitted_value,
   output logic                                 fit_last,
   output logic                                 overflow_flag
);

   localparam int ENT_W = ipava_pkg::SUM_W + ipava_pkg::CNT_W;

   logic [ENT_W-1:0] pool_mem [ipava_pkg::MAX_LEN];

   logic                                 dir_ff, dir_in;
   logic signed [ipava_pkg::SUM_W-1:0]   top_sum_ff, top_sum_in;
   logic        [ipava_pkg::CNT_W-1:0]   top_cnt_ff, top_cnt_in;
   logic        [ipava_pkg::CNT_W-1:0]   pool_top_ff, pool_top_in;
   logic        [ipava_pkg::CNT_W-1:0]   sample_count_ff, sample_count_in;
   logic                                 dropped_ff, dropped_in;
   logic        [ENT_W-1:0]              rd_data_ff;
   logic signed [ipava_pkg::PROD_W-1:0]  lhs_ff, rhs_ff;
   logic        [ipava_pkg::IDX_W-1:0]   emit_idx_ff, emit_idx_in;
   logic        [ipava_pkg::CNT_W-1:0]   emit_k_ff, emit_k_in;
   logic        [ipava_pkg::CNT_W-1:0]   emit_cnt_ff, emit_cnt_in;

   logic signed [ipava_pkg::SUM_W-1:0]   lo_sum;
   logic        [ipava_pkg::CNT_W-1:0]   lo_cnt;
   logic                                 wr_en;
   logic        [ipava_pkg::IDX_W-1:0]   wr_addr;
   logic        [ipava_pkg::IDX_W-1:0]   rd_addr;
   logic        [ipava_pkg::CNT_W-1:0]   top_m1, top_m2;
   logic                                 div_busy;
   logic        [ipava_pkg::DATA_W-1:0]  quotient;

   assign lo_sum = rd_data_ff[ENT_W-1:ipava_pkg::CNT_W];
   assign lo_cnt = rd_data_ff[ipava_pkg::CNT_W-1:0];
   assign top_m1 = pool_top_ff - 1'b1;
   assign top_m2 = pool_top_ff - 2'd2;

   // memory port control
   assign wr_en   = (cmd.accept && status.cap_ok && (pool_top_ff != '0)) || cmd.flush;
   assign wr_addr = top_m1[ipava_pkg::IDX_W-1:0];
   assign rd_addr = cmd.emit_rd ? emit_idx_ff : top_m2[ipava_pkg::IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pool_mem[wr_addr] <= {top_sum_ff, top_cnt_ff};
      end
      if (cmd.rd_lo || cmd.emit_rd) begin
         rd_data_ff <= pool_mem[rd_addr];
      end
   end

   // cross-multiplied means of the two topmost pools
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         lhs_ff <= lo_sum * $signed({1'b0, top_cnt_ff});
         rhs_ff <= top_sum_ff * $signed({1'b0, lo_cnt});
      end
   end

   // stack and readout state
   always_comb begin
      dir_in          = csr_wr_en ? csr_wr_data : dir_ff;
      top_sum_in      = top_sum_ff;
      top_cnt_in      = top_cnt_ff;
      pool_top_in     = pool_top_ff;
      sample_count_in = sample_count_ff;
      dropped_in      = dropped_ff;
      emit_idx_in     = emit_idx_ff;
      emit_k_in       = emit_k_ff;
      emit_cnt_in     = emit_cnt_ff;
      if (cmd.accept) begin
         if (status.cap_ok) begin
            top_sum_in      = ipava_pkg::SUM_W'(sample_value);
            top_cnt_in      = ipava_pkg::CNT_W'(1);
            pool_top_in     = pool_top_ff + 1'b1;
            sample_count_in = sample_count_ff + 1'b1;
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.merge) begin
         top_sum_in  = top_sum_ff + lo_sum;
         top_cnt_in  = top_cnt_ff + lo_cnt;
         pool_top_in = pool_top_ff - 1'b1;
      end
      if (cmd.flush) begin
         emit_idx_in = '0;
      end
      if (cmd.div_start) begin
         emit_cnt_in = lo_cnt;
         emit_k_in   = '0;
      end
      if (cmd.emit_out) begin
         if (status.k_last) begin
            emit_idx_in = emit_idx_ff + 1'b1;
         end else begin
            emit_k_in = emit_k_ff + 1'b1;
         end
      end
      if (cmd.clear) begin
         pool_top_in     = '0;
         sample_count_in = '0;
         dropped_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff          <= 1'b1;
         pool_top_ff     <= '0;
         sample_count_ff <= '0;
         dropped_ff      <= 1'b0;
      end else begin
         dir_ff          <= dir_in;
         pool_top_ff     <= pool_top_in;
         sample_count_ff <= sample_count_in;
         dropped_ff      <= dropped_in;
      end
      top_sum_ff  <= top_sum_in;
      top_cnt_ff  <= top_cnt_in;
      emit_idx_ff <= emit_idx_in;
      emit_k_ff   <= emit_k_in;
      emit_cnt_ff <= emit_cnt_in;
   end

   // pool mean
   ipava_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (lo_sum),
      .divisor  (lo_cnt),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // status to controller
   assign status.cap_ok   = (sample_count_ff < ipava_pkg::CNT_W'(ipava_pkg::MAX_LEN));
   assign status.top_ge2  = (pool_top_ff >= ipava_pkg::CNT_W'(2));
   assign status.violates = dir_ff ? (lhs_ff > rhs_ff) : (lhs_ff < rhs_ff);
   assign status.div_busy = div_busy;
   assign status.k_last   = (emit_k_ff == (emit_cnt_ff - 1'b1));
   assign status.idx_last = ({1'b0, emit_idx_ff} == top_m1);

   assign fitted_value  = $signed(quotient);
   assign fit_last      = status.k_last && status.idx_last;
   assign overflow_flag = dropped_ff;

`ifndef SYNTHESIS
   a_top_le_count: assert property (@(posedge clock) disable iff (reset)
      pool_top_ff <= sample_count_ff)
      else $error("more pools than samples");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      sample_count_ff <= ipava_pkg::CNT_W'(ipava_pkg::MAX_LEN))
      else $error("sample count beyond capacity");
   a_merge_two: assert property (@(posedge clock) disable iff (reset)
      cmd.merge |-> pool_top_ff >= ipava_pkg::CNT_W'(2))
      else $error("merge with fewer than two pools");
   a_emit_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_out |-> (emit_cnt_ff != '0 && !div_busy))
      else $error("emit from empty pool or busy divider");
`endif

endmodule

// ===== rtl/ipava_ctrl.sv =====
// controller: sequences push, merge loop and readout
module ipava_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  sample_last,
   input  ipava_pkg::status_type status,
   output ipava_pkg::cmd_type    cmd,
   output logic                  busy
);

   ipava_pkg::state_type state_ff, state_in;
   logic                 last_ff, last_in;

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      cmd      = '0;
      unique case (state_ff)
         ipava_pkg::ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               last_in    = sample_last;
               if (status.cap_ok) begin
                  state_in = ipava_pkg::ST_READ;
               end else if (sample_last) begin
                  state_in = ipava_pkg::ST_FLUSH;
               end
            end
         end
         ipava_pkg::ST_READ: begin
            if (status.top_ge2) begin
               cmd.rd_lo = 1'b1;
               state_in  = ipava_pkg::ST_MULT;
            end else begin
               state_in = last_ff ? ipava_pkg::ST_FLUSH : ipava_pkg::ST_IDLE;
            end
         end
         ipava_pkg::ST_MULT: begin
            cmd.mul  = 1'b1;
            state_in = ipava_pkg::ST_CMP;
         end
         ipava_pkg::ST_CMP: begin
            if (status.violates) begin
               cmd.merge = 1'b1;
               state_in  = ipava_pkg::ST_READ;
            end else begin
               state_in = last_ff ? ipava_pkg::ST_FLUSH : ipava_pkg::ST_IDLE;
            end
         end
         ipava_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ipava_pkg::ST_ERD;
         end
         ipava_pkg::ST_ERD: begin
            cmd.emit_rd = 1'b1;
            state_in    = ipava_pkg::ST_ELOAD;
         end
         ipava_pkg::ST_ELOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ipava_pkg::ST_EDIV;
         end
         ipava_pkg::ST_EDIV: begin
            if (!status.div_busy) begin
               state_in = ipava_pkg::ST_EOUT;
            end
         end
         ipava_pkg::ST_EOUT: begin
            cmd.emit_out = 1'b1;
            if (status.k_last) begin
               state_in = status.idx_last ? ipava_pkg::ST_CLEAR : ipava_pkg::ST_ERD;
            end
         end
         ipava_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = ipava_pkg::ST_IDLE;
         end
         default: begin
            state_in = ipava_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipava_pkg::ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   assign busy = (state_ff != ipava_pkg::ST_IDLE);

`ifndef SYNTHESIS
   a_busy_after_push: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && status.cap_ok) |=> busy)
      else $error("controller idle after pushed transaction");
   a_out_not_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_out |-> busy)
      else $error("result strobe while idle");
   a_div_then_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> state_ff == ipava_pkg::ST_EDIV)
      else $error("divider started outside readout");
`endif

endmodule

// ===== rtl/isotonic_pava_fit.sv =====
// top level of the streaming isotonic fit by pooling adjacent violators
// a sample that leaves only one pool is pushed with no merge test; else each merge test takes one memory
// read, one registered cross multiply and one compare
// on the last sample each pool's mean comes from a 38-step divider,
// then one result per cycle for each sample in it; the receiver cannot stall
// synchronous active-high reset clears the stack and sets the increasing fit
module isotonic_pava_fit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [ipava_pkg::DATA_W-1:0]  req_sample_value,
   input  logic                                 req_sample_last,
   output logic                                 rsp_valid,
   output logic signed [ipava_pkg::DATA_W-1:0]  rsp_fitted_value,
   output logic                                 rsp_fit_last,
   output logic                                 rsp_overflow_flag,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_wr_data
);

   ipava_pkg::cmd_type    cmd;
   ipava_pkg::status_type status;

   // sequencing
   ipava_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .sample_last (req_sample_last),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   // pools and arithmetic
   ipava_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .sample_value  (req_sample_value),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fitted_value  (rsp_fitted_value),
      .fit_last      (rsp_fit_last),
      .overflow_flag (rsp_overflow_flag)
   );

   // one result transaction per strobe
   assign rsp_valid = cmd.emit_out;

endmodule
